[hdl/sarpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sarpd_pkg;

	// Command codes
	localparam logic [2:0] OP_SET     = 3'd0;
	localparam logic [2:0] OP_OPEN    = 3'd1;
	localparam logic [2:0] OP_CLOSE   = 3'd2;
	localparam logic [2:0] OP_RAMP    = 3'd3;
	localparam logic [2:0] OP_DISABLE = 3'd4;
	localparam logic [2:0] OP_ENABLE  = 3'd5;

	// Configuration register indexes
	localparam logic [2:0] REG_MIN_PULSE  = 3'd0;
	localparam logic [2:0] REG_PULSE_SPAN = 3'd1;
	localparam logic [2:0] REG_MAX_ANGLE  = 3'd2;
	localparam logic [2:0] REG_CLOSED     = 3'd3;
	localparam logic [2:0] REG_OPEN       = 3'd4;
	localparam logic [2:0] REG_PERIOD     = 3'd5;

	// Door position codes
	localparam logic [1:0] DOOR_CLOSED  = 2'd0;
	localparam logic [1:0] DOOR_OPEN    = 2'd1;
	localparam logic [1:0] DOOR_UNKNOWN = 2'd2;

	localparam int unsigned DOOR_TOL = 5;

	typedef struct packed {
		logic [2:0]  operation;
		logic [9:0]  angle;
		logic [15:0] ramp_ms;
	} cmd_t;

	typedef struct packed {
		logic [12:0] duty_cmp;
		logic [9:0]  angle_now;
		logic [1:0]  door_state;
		logic        enabled;
		logic        status;
		logic [10:0] hold_ms;
		logic        last;
	} res_t;

endpackage

`default_nettype wire

[hdl/servo_angle_ramp_pwm_duty_top.sv]
// Servo pulse-width ramp generator.
// Commands arrive on the cmd channel (valid/ready) and results leave on the res
// channel (valid/ready); an item is moved when valid and ready are both high.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the block is idle, which the block does not
// enforce. Every command gives one result, except a ramp to a new angle, which
// gives RAMP_STEPS+1 results (fewer if a point is rejected), the final one
// marked last. All divisions go through one restoring divider that resolves one
// quotient bit per cycle over NUM_W bits (26 at the default parameters);
// it sets the timing. A set, open or close command runs up to two divisions
// (pulse, then duty); a ramp divides out the hold time, then runs up to three
// per point (point, pulse, duty). One command is processed at a time; cmd_ready
// is high only while the sequencer is idle, so the next command may be taken
// while the last result still waits in the output register. If the receiver
// stalls, the result stays in the output register and the sequencer waits
// before writing the next one; nothing is dropped.
// Reset puts the configuration registers at their defaults, the angle at zero,
// the door closed and the output disabled with a zero duty value.
`timescale 1ns / 1ps
`default_nettype none

module servo_angle_ramp_pwm_duty_top import sarpd_pkg::*; #(
	parameter int unsigned DUTY_FULL_SCALE = 8191,
	parameter int unsigned RAMP_STEPS      = 50
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_ready,
	input  wire cmd_t        cmd,
	output logic             res_valid,
	input  wire logic        res_ready,
	output res_t             res,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int unsigned DFS_W  = $clog2(DUTY_FULL_SCALE + 1);
	localparam int unsigned N_W    = $clog2(RAMP_STEPS + 1);
	localparam int unsigned V_W    = 10 + N_W;
	localparam int unsigned PROD_W = 13 + DFS_W;
	localparam int unsigned RN_W   = V_W + 1;
	localparam int unsigned M1_W   = (PROD_W > 22) ? PROD_W : 22;
	localparam int unsigned M2_W   = (M1_W > RN_W) ? M1_W : RN_W;
	localparam int unsigned NUM_W  = (M2_W > 16) ? M2_W : 16;
	localparam int unsigned DEN_W  = 16;
	localparam int unsigned CNT_W  = $clog2(NUM_W + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_HOLD  = 3'd1;
	localparam logic [2:0] ST_POINT = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_PDIV  = 3'd4;
	localparam logic [2:0] ST_CHECK = 3'd5;
	localparam logic [2:0] ST_DDIV  = 3'd6;
	localparam logic [2:0] ST_EMIT  = 3'd7;

	// Configuration
	logic [11:0] min_pulse_q;
	logic [11:0] span_q;
	logic [9:0]  max_angle_q;
	logic [9:0]  closed_q;
	logic [9:0]  open_q;
	logic [15:0] period_q;

	// Block state
	logic [2:0]        state_q;
	logic [9:0]        cur_q;
	logic [1:0]        door_q;
	logic              en_q;
	logic [12:0]       duty_q;
	logic [N_W-1:0]    step_q;
	logic              ramp_q;
	logic [9:0]        ang_q;
	logic [12:0]       pulse_q;
	logic [10:0]       hold_q;
	logic [V_W-1:0]    v_q;
	logic signed [10:0] diff_q;
	logic              st_q;
	logic              last_q;

	// Output register
	res_t res_q;
	logic res_valid_q;
	logic res_load;

	// Divider
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic [DEN_W:0]   rem_shift;
	logic             rem_ge;
	logic             div_done;

	logic [9:0]        src_angle;
	logic [9:0]        src_clamped;
	logic [9:0]        pt_clamped;
	logic [9:0]        ramp_target;
	logic [15:0]       per_eff;
	logic [21:0]       mul_a;
	logic [PROD_W-1:0] mul_b;
	logic [V_W-1:0]    v_start;
	logic [V_W-1:0]    v_next;
	logic [V_W-1:0]    v_sel;
	logic [1:0]        door_next;
	logic              out_free;
	logic              step_end;

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		case (cmd.operation)
			OP_OPEN:  src_angle = open_q;
			OP_CLOSE: src_angle = closed_q;
			default:  src_angle = cmd.angle;
		endcase
	end

	assign src_clamped = (src_angle > max_angle_q) ? max_angle_q : src_angle;
	assign ramp_target = (cmd.angle > max_angle_q) ? max_angle_q : cmd.angle;
	assign pt_clamped  = (quo_q[9:0] > max_angle_q) ? max_angle_q : quo_q[9:0];
	assign per_eff     = (period_q == 16'd0) ? 16'd1 : period_q;

	assign mul_a   = {12'd0, ang_q} * {10'd0, span_q};
	assign mul_b   = PROD_W'(pulse_q) * PROD_W'(DUTY_FULL_SCALE);
	assign v_start = V_W'(cur_q) * V_W'(RAMP_STEPS);
	assign v_next  = v_q + V_W'($signed(diff_q));
	assign v_sel   = (state_q == ST_HOLD) ? v_start : v_next;

	assign out_free = !res_valid_q || res_ready;
	assign step_end = (step_q == N_W'(RAMP_STEPS));
	assign res_load = (state_q == ST_EMIT) && out_free;

	always_comb begin
		if ({1'b0, ang_q} <= {1'b0, closed_q} + 11'(DOOR_TOL)) begin
			door_next = DOOR_CLOSED;
		end else if ({1'b0, ang_q} + 11'(DOOR_TOL) >= {1'b0, open_q}) begin
			door_next = DOOR_OPEN;
		end else begin
			door_next = DOOR_UNKNOWN;
		end
	end

	// Divider operand selection: each division is launched from the state before it.
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && cmd.operation == OP_RAMP && ramp_target != cur_q) begin
					div_start = 1'b1;
					div_num   = NUM_W'(cmd.ramp_ms);
					div_den   = DEN_W'(RAMP_STEPS);
				end
			end
			ST_HOLD: begin
				if (div_done) begin
					div_start = 1'b1;
					div_num   = NUM_W'({v_sel, 1'b0}) + NUM_W'(RAMP_STEPS);
					div_den   = DEN_W'(2 * RAMP_STEPS);
				end
			end
			ST_MUL: begin
				if (max_angle_q != 10'd0) begin
					div_start = 1'b1;
					div_num   = NUM_W'(mul_a);
					div_den   = DEN_W'(max_angle_q);
				end
			end
			ST_CHECK: begin
				if ({3'd0, pulse_q} <= per_eff) begin
					div_start = 1'b1;
					div_num   = NUM_W'(mul_b);
					div_den   = per_eff;
				end
			end
			ST_EMIT: begin
				if (out_free && !last_q) begin
					div_start = 1'b1;
					div_num   = NUM_W'({v_sel, 1'b0}) + NUM_W'(RAMP_STEPS);
					div_den   = DEN_W'(2 * RAMP_STEPS);
				end
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// Restoring division, one quotient bit per cycle.
	assign rem_shift = {rem_q, quo_q[NUM_W-1]};
	assign rem_ge    = (rem_shift >= {1'b0, den_q});
	assign div_done  = (div_cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (div_start) begin
			div_cnt_q <= CNT_W'(NUM_W);
		end else if (!div_done) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			quo_q <= div_num;
			rem_q <= '0;
			den_q <= div_den;
		end else if (!div_done) begin
			quo_q <= {quo_q[NUM_W-2:0], rem_ge};
			rem_q <= rem_ge ? DEN_W'(rem_shift - {1'b0, den_q}) : DEN_W'(rem_shift);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q <= 12'd500;
			span_q      <= 12'd2000;
			max_angle_q <= 10'd180;
			closed_q    <= 10'd0;
			open_q      <= 10'd90;
			period_q    <= 16'd20000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_PULSE:  min_pulse_q <= cfg_data[11:0];
				REG_PULSE_SPAN: span_q      <= cfg_data[11:0];
				REG_MAX_ANGLE:  max_angle_q <= cfg_data[9:0];
				REG_CLOSED:     closed_q    <= cfg_data[9:0];
				REG_OPEN:       open_q      <= cfg_data[9:0];
				REG_PERIOD:     period_q    <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			door_q      <= DOOR_CLOSED;
			en_q        <= 1'b0;
			duty_q      <= '0;
			step_q      <= '0;
			ramp_q      <= 1'b0;
			ang_q       <= '0;
			pulse_q     <= '0;
			hold_q      <= '0;
			v_q         <= '0;
			diff_q      <= '0;
			st_q        <= 1'b0;
			last_q      <= 1'b1;
			res_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						st_q   <= 1'b0;
						last_q <= 1'b1;
						ramp_q <= 1'b0;
						case (cmd.operation)
							OP_SET, OP_OPEN, OP_CLOSE: begin
								ang_q   <= src_clamped;
								state_q <= ST_MUL;
							end
							OP_RAMP: begin
								ramp_q <= 1'b1;
								diff_q <= $signed({1'b0, ramp_target}) - $signed({1'b0, cur_q});
								if (ramp_target == cur_q) begin
									state_q <= ST_EMIT;
								end else begin
									state_q <= ST_HOLD;
								end
							end
							OP_DISABLE: begin
								en_q    <= 1'b0;
								duty_q  <= '0;
								state_q <= ST_EMIT;
							end
							OP_ENABLE: begin
								if (!en_q) begin
									en_q   <= 1'b1;
									duty_q <= '0;
								end
								state_q <= ST_EMIT;
							end
							default: begin
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_HOLD: begin
					if (div_done) begin
						hold_q  <= quo_q[10:0];
						v_q     <= v_start;
						step_q  <= '0;
						state_q <= ST_POINT;
					end
				end
				ST_POINT: begin
					if (div_done) begin
						ang_q   <= pt_clamped;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (max_angle_q == 10'd0) begin
						pulse_q <= {1'b0, min_pulse_q};
						state_q <= ST_CHECK;
					end else begin
						state_q <= ST_PDIV;
					end
				end
				ST_PDIV: begin
					if (div_done) begin
						pulse_q <= {1'b0, min_pulse_q} + {1'b0, quo_q[11:0]};
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if ({3'd0, pulse_q} > per_eff) begin
						// Pulse longer than the period: nothing changes and a ramp stops here.
						st_q    <= 1'b1;
						last_q  <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_DDIV;
					end
				end
				ST_DDIV: begin
					if (div_done) begin
						en_q    <= 1'b1;
						duty_q  <= quo_q[12:0];
						cur_q   <= ang_q;
						door_q  <= door_next;
						st_q    <= 1'b0;
						last_q  <= !ramp_q || step_end;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						res_q.duty_cmp   <= en_q ? duty_q : 13'd0;
						res_q.angle_now  <= cur_q;
						res_q.door_state <= door_q;
						res_q.enabled    <= en_q;
						res_q.status     <= st_q;
						res_q.hold_ms    <= last_q ? 11'd0 : hold_q;
						res_q.last       <= last_q;
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							step_q  <= step_q + 1'b1;
							v_q     <= v_next;
							state_q <= ST_POINT;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/sarpd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module sarpd_checker import sarpd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire logic cmd_ready,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire res_t res
);

	// A result that is not taken stays as it is.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// A disabled output always reports a zero duty value.
	a_duty_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.enabled |-> res.duty_cmp == 13'd0)
		else $error("non-zero duty while disabled");

	// A rejected pulse ends the command.
	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status |-> res.last)
		else $error("rejection not marked last");

	// The final item of a command carries no hold time.
	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |-> res.hold_ms == 11'd0)
		else $error("hold time on final item");

	// After taking a command the block is not ready in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while busy");

endmodule

bind servo_angle_ramp_pwm_duty_top sarpd_checker u_sarpd_checker (.*);

`default_nettype wire

[test/servo_ramp_checker.sv]
`timescale 1ns / 1ps

module servo_ramp_checker import sarpd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	input  wire logic        cmd_ready,
	input  wire cmd_t        cmd,
	input  wire logic        res_valid,
	input  wire logic        res_ready,
	input  wire res_t        res,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output int               mismatches,
	output int               pending
);

	localparam int unsigned FULL_SCALE = 8191;
	localparam int          STEPS      = 50;

	logic [11:0] min_pulse;
	logic [11:0] span;
	logic [9:0]  max_ang;
	logic [9:0]  closed_ang;
	logic [9:0]  open_ang;
	logic [15:0] period;

	logic [9:0]  angle_now;
	logic [1:0]  door;
	logic        out_en;
	logic [12:0] duty;

	res_t        expected_results[$];
	int          failures = 0;

	task automatic restore_defaults;
		min_pulse  = 500;
		span       = 2000;
		max_ang    = 180;
		closed_ang = 0;
		open_ang   = 90;
		period     = 20000;
		angle_now  = '0;
		door       = DOOR_CLOSED;
		out_en     = 1'b0;
		duty       = '0;
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
		case (idx)
			REG_MIN_PULSE: begin
				min_pulse = data[11:0];
			end
			REG_PULSE_SPAN: begin
				span = data[11:0];
			end
			REG_MAX_ANGLE: begin
				max_ang = data[9:0];
			end
			REG_CLOSED: begin
				closed_ang = data[9:0];
			end
			REG_OPEN: begin
				open_ang = data[9:0];
			end
			REG_PERIOD: begin
				period = data;
			end
			default: begin
			end
		endcase
	endtask

	// Returns 1 when the pulse would be longer than the period; nothing changes then.
	function automatic bit move_to_angle(input int unsigned a);
		longint unsigned pulse;
		longint unsigned per;
		if (a > max_ang)
			a = max_ang;
		pulse = min_pulse;
		if (max_ang != 0)
			pulse += (64'(a) * span) / max_ang;
		per = (period == 0) ? 64'd1 : 64'(period);
		if (pulse > per)
			return 1'b1;
		if (!out_en) begin
			out_en = 1'b1;
			duty   = '0;
		end
		duty      = 13'((pulse * FULL_SCALE) / per);
		angle_now = 10'(a);
		if (angle_now <= closed_ang + DOOR_TOL)
			door = DOOR_CLOSED;
		else if (angle_now + DOOR_TOL >= open_ang)
			door = DOOR_OPEN;
		else
			door = DOOR_UNKNOWN;
		return 1'b0;
	endfunction

	function automatic res_t snapshot(input bit rejected, input int unsigned hold, input bit fin);
		res_t r;
		r.duty_cmp   = out_en ? duty : '0;
		r.angle_now  = angle_now;
		r.door_state = door;
		r.enabled    = out_en;
		r.status     = rejected;
		r.hold_ms    = 11'(hold);
		r.last       = fin;
		return r;
	endfunction

	function automatic void predict_servo(input cmd_t c);
		longint      start_a;
		longint      target_a;
		longint      diff;
		longint      num;
		int unsigned hold;
		int unsigned a;
		case (c.operation)
			OP_SET, OP_OPEN, OP_CLOSE: begin
				if (c.operation == OP_SET)
					a = c.angle;
				else if (c.operation == OP_OPEN)
					a = open_ang;
				else
					a = closed_ang;
				expected_results.push_back(snapshot(move_to_angle(a), 0, 1'b1));
			end
			OP_RAMP: begin
				start_a  = angle_now;
				target_a = (c.angle > max_ang) ? max_ang : c.angle;
				diff     = target_a - start_a;
				hold     = c.ramp_ms / STEPS;
				if (diff == 0) begin
					expected_results.push_back(snapshot(1'b0, 0, 1'b1));
				end else begin
					for (int i = 0; i <= STEPS; i++) begin
						// Round half up: (2*(start*N + diff*i) + N) / 2N.
						num = 2 * (start_a * STEPS + diff * i) + STEPS;
						if (num < 0)
							num = 0;
						if (move_to_angle(32'(num / (2 * STEPS)))) begin
							expected_results.push_back(snapshot(1'b1, 0, 1'b1));
							break;
						end
						if (i == STEPS)
							expected_results.push_back(snapshot(1'b0, 0, 1'b1));
						else
							expected_results.push_back(snapshot(1'b0, hold, 1'b0));
					end
				end
			end
			OP_DISABLE: begin
				out_en = 1'b0;
				duty   = '0;
				expected_results.push_back(snapshot(1'b0, 0, 1'b1));
			end
			OP_ENABLE: begin
				if (!out_en) begin
					out_en = 1'b1;
					duty   = '0;
				end
				expected_results.push_back(snapshot(1'b0, 0, 1'b1));
			end
			default: begin
				expected_results.push_back(snapshot(1'b0, 0, 1'b1));
			end
		endcase
	endfunction

	function automatic void compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			failures++;
		end
	endfunction

	function automatic void check_result(input res_t got);
		res_t want;
		if (expected_results.size() == 0) begin
			$display("%0t ns: result with none expected: duty %0d angle %0d last %0d",
				$time, got.duty_cmp, got.angle_now, got.last);
			failures++;
			return;
		end
		want = expected_results.pop_front();
		compare_field("duty_cmp", want.duty_cmp, got.duty_cmp);
		compare_field("angle_now", want.angle_now, got.angle_now);
		compare_field("door_state", want.door_state, got.door_state);
		compare_field("enabled", want.enabled, got.enabled);
		compare_field("status", want.status, got.status);
		compare_field("hold_ms", want.hold_ms, got.hold_ms);
		compare_field("last", want.last, got.last);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restore_defaults();
			expected_results.delete();
			pending    <= 0;
			mismatches <= failures;
		end else begin
			if (res_valid && res_ready)
				check_result(res);
			if (cfg_we)
				write_register(cfg_index, cfg_data);
			if (cmd_valid && cmd_ready)
				predict_servo(cmd);
			pending    <= expected_results.size();
			mismatches <= failures;
		end
	end

endmodule

[test/servo_angle_ramp_pwm_duty_top_tb.sv]
`timescale 1ns / 1ps

module servo_angle_ramp_pwm_duty_top_tb;
	import sarpd_pkg::*;

	// Operation codes with no function; the block only echoes its state.
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_ready;
	cmd_t        cmd;
	logic        res_valid;
	logic        res_ready;
	res_t        res;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	int          mismatches;
	int          pending;
	int          send_gap_pct = 0;
	int          stall_pct    = 0;
	int unsigned angle_limit  = 180;

	servo_angle_ramp_pwm_duty_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	servo_ramp_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("servo_angle_ramp_pwm_duty_top_tb NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Valid stays high into the next item unless a gap is drawn.
	task automatic send(input cmd_t c);
		while ($urandom_range(99) < send_gap_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (!cmd_ready);
	endtask

	task automatic send_op(input logic [2:0] op, input int unsigned ang, input int unsigned dur);
		cmd_t c;
		c.operation = op;
		c.angle     = 10'(ang);
		c.ramp_ms   = 16'(dur);
		send(c);
	endtask

	task automatic send_random;
		int unsigned pick;
		logic [2:0]  op;
		pick = $urandom_range(99);
		if (pick < 25)
			op = OP_SET;
		else if (pick < 33)
			op = OP_OPEN;
		else if (pick < 41)
			op = OP_CLOSE;
		else if (pick < 71)
			op = OP_RAMP;
		else if (pick < 80)
			op = OP_DISABLE;
		else if (pick < 90)
			op = OP_ENABLE;
		else if (pick < 95)
			op = OP_SPARE_6;
		else
			op = OP_SPARE_7;
		if ($urandom_range(3) == 0)
			send_op(op, $urandom_range(1023), $urandom);
		else
			send_op(op, $urandom_range(angle_limit), $urandom);
	endtask

	task automatic wait_idle;
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic configure(input int unsigned min_us, input int unsigned span_us,
			input int unsigned max_a, input int unsigned closed_a,
			input int unsigned open_a, input int unsigned per_us);
		logic [2:0]  regs[6];
		logic [15:0] vals[6];
		wait_idle();
		regs = '{REG_MIN_PULSE, REG_PULSE_SPAN, REG_MAX_ANGLE, REG_CLOSED, REG_OPEN, REG_PERIOD};
		vals = '{16'(min_us), 16'(span_us), 16'(max_a), 16'(closed_a), 16'(open_a),
			16'(per_us)};
		for (int i = 0; i < 6; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we      <= 1'b0;
		angle_limit = max_a;
	endtask

	initial begin
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_MIN_PULSE;
		cfg_data  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 19;
		stall_pct    = 19;
		send_op(OP_ENABLE, 0, 0);
		send_op(OP_SET, 0, 0);
		send_op(OP_SET, 1023, 65535);
		send_op(OP_OPEN, 0, 0);
		send_op(OP_CLOSE, 0, 0);
		send_op(OP_RAMP, 0, 1234);
		send_op(OP_RAMP, 180, 65535);
		send_op(OP_RAMP, 0, 0);
		send_op(OP_DISABLE, 0, 0);
		send_op(OP_SET, 45, 0);
		send_op(OP_DISABLE, 0, 0);
		send_op(OP_ENABLE, 0, 0);
		send_op(OP_SPARE_6, 0, 0);
		send_op(OP_SPARE_7, 1023, 65535);
		send_op(OP_RAMP, 1023, 49);
		send_op(OP_RAMP, 177, 100);

		// A short period rejects wide pulses, which also cuts a ramp short.
		configure(500, 2000, 180, 0, 90, 1000);
		send_op(OP_SET, 180, 0);
		send_op(OP_SET, 0, 0);
		send_op(OP_RAMP, 180, 500);

		// A zero maximum angle pins every angle at zero; a zero period counts as one.
		configure(1, 4095, 0, 0, 3, 0);
		send_op(OP_SET, 500, 0);
		send_op(OP_RAMP, 5, 700);
		configure(2, 4095, 0, 0, 3, 0);
		send_op(OP_SET, 0, 0);

		// With the open angle below the tolerance, anything past closed reads as open.
		configure(0, 4095, 1023, 0, 3, 65535);
		send_op(OP_SET, 4, 0);
		send_op(OP_SET, 8, 0);
		send_op(OP_OPEN, 0, 0);
		send_op(OP_RAMP, 1023, 65535);

		send_gap_pct = 0;
		stall_pct    = 0;
		configure(500, 2000, 180, 0, 90, 20000);
		repeat (27) send_random();

		send_gap_pct = 77;
		stall_pct    = 0;
		configure(4095, 4095, 1023, 1023, 1023, 65535);
		repeat (27) send_random();

		send_gap_pct = 0;
		stall_pct    = 77;
		configure(0, 0, 1, 0, 0, 1);
		repeat (27) send_random();

		send_gap_pct = 19;
		stall_pct    = 19;
		configure($urandom_range(4095), $urandom_range(4095), $urandom_range(1, 1023),
			$urandom_range(1023), $urandom_range(1023), $urandom_range(2000, 65535));
		repeat (27) send_random();

		send_gap_pct = 0;
		stall_pct    = 0;
		configure($urandom_range(4095), $urandom_range(4095), $urandom_range(1, 1023),
			$urandom_range(1023), $urandom_range(1023), $urandom_range(1, 65535));
		repeat (27) send_random();

		wait_idle();
		stall_pct = 0;
		// Give a stray result time to show up before the verdict.
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("servo_angle_ramp_pwm_duty_top_tb OK");
		else
			$display("servo_angle_ramp_pwm_duty_top_tb NOT OK");
		$finish;
	end

endmodule
